[rtl/core/sgmb_pkg.sv]
// ---------------------------------------------------------------------------
// sgmb_pkg
// Shared constants and types of the SiLU-gated multiply backward block.
// ---------------------------------------------------------------------------
package sgmb_pkg;

   // default datapath format: signed Q5.10
   localparam int SGMB_DATA_BITS       = 16;
   localparam int SGMB_FRAC_BITS       = 10;
   localparam int SGMB_SIGMOID_ENTRIES = 256;

   // stage enables of the sigmoid front end
   typedef struct packed {
      logic idx_en;
      logic rom_en;
      logic sel_en;
   } sgmb_sig_ctl_type;

endpackage

[rtl/core/sgmb_if.sv]
// ---------------------------------------------------------------------------
// sgmb request and response channels
// Valid/ready channels carrying one element and its two gradients.
// ---------------------------------------------------------------------------
interface sgmb_req_if
   import sgmb_pkg::*;
#(
   parameter int DATA_BITS = SGMB_DATA_BITS
) ();

   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] gate_value;
   logic signed [DATA_BITS-1:0] up_value;
   logic signed [DATA_BITS-1:0] upstream_gradient;
   logic                        last_element;

   modport source (
      output valid, gate_value, up_value, upstream_gradient, last_element,
      input  ready
   );

   modport sink (
      input  valid, gate_value, up_value, upstream_gradient, last_element,
      output ready
   );

endinterface

interface sgmb_rsp_if
   import sgmb_pkg::*;
#(
   parameter int DATA_BITS = SGMB_DATA_BITS
) ();

   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] gate_gradient;
   logic signed [DATA_BITS-1:0] up_gradient;
   logic                        saturated;
   logic                        last_out;

   modport source (
      output valid, gate_gradient, up_gradient, saturated, last_out,
      input  ready
   );

   modport sink (
      input  valid, gate_gradient, up_gradient, saturated, last_out,
      output ready
   );

endinterface

[rtl/core/silu_gated_multiply_backward_top.sv]
// ---------------------------------------------------------------------------
// silu_gated_multiply_backward_top
// Backward pass of the SiLU-gated product: per element returns
// d*u*dsilu(g) and d*silu(g), in saturating signed fixed point.
// ---------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   gate_value, up_value, upstream_gradient,
//                              last_element
//  rsp_ch   out  valid/ready   gate_gradient, up_gradient, saturated, last_out
//
//  one element per cycle sustained while the output is not held; a result
//  passes eleven register stages (three sigmoid, eight multiply/round)
//  before it is offered at the output
//  reset clears only the stage valid bits
//  each stage holds while the stage after it is full and held; empty stages
//  fill, so a stalled output still lets the pipe take input until it is full
// ---------------------------------------------------------------------------
module silu_gated_multiply_backward_top
   import sgmb_pkg::*;
#(
   parameter int DATA_BITS       = SGMB_DATA_BITS,
   parameter int FRAC_BITS       = SGMB_FRAC_BITS,
   parameter int SIGMOID_ENTRIES = SGMB_SIGMOID_ENTRIES
) (
   input  logic      clock,
   input  logic      reset,
   sgmb_req_if.sink   req_ch,
   sgmb_rsp_if.source rsp_ch
);

   localparam int D    = DATA_BITS;
   localparam int F    = FRAC_BITS;
   localparam int NS   = 11;
   localparam int ONE  = 1 << F;
   localparam int HALF = 1 << (F - 1);
   localparam int P1W  = D + F + 2;
   localparam int SLW  = D + 1;
   localparam int WW   = ((D + 1 > F + 2) ? D + 1 : F + 2) + 1;
   localparam int P3W  = F + 2 + WW;
   localparam int DSW  = F + 2;
   localparam int P4W  = D + SLW;
   localparam int GUW  = P4W + 1;
   localparam int P5W  = D + DSW;
   localparam int UDW  = D + 2;
   localparam int P6W  = D + UDW;
   localparam int GGW  = P6W + 1;
   localparam logic signed [P3W:0] DS_LIM = (P3W + 1)'(2 * ONE - 1);
   localparam logic signed [D-1:0] D_MAX  = {1'b0, {(D - 1){1'b1}}};
   localparam logic signed [D-1:0] D_MIN  = {1'b1, {(D - 1){1'b0}}};

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] stage_en;

   // carried operands, index = stage (gu_ff: index = stage - 6)
   logic signed [D-1:0]   g_ff    [3];
   logic signed [D-1:0]   u_ff    [7];
   logic signed [D-1:0]   d_ff    [9];
   logic                  last_ff [10];
   logic signed [GUW-1:0] gu_ff   [4];

   sgmb_sig_ctl_type      sig_ctl;
   logic [F:0]            sig_s2;
   logic [F:0]            om_s2;

   logic signed [P1W-1:0] p1_in, p1_ff, p2_in, p2_ff;
   logic [F:0]            sig3_ff, sig4_ff;
   logic signed [P1W:0]   p1_sum, p1_rnd, p2_sum, p2_rnd;
   logic signed [SLW-1:0] silu_ff;
   logic signed [WW-1:0]  w_in, w_ff;
   logic signed [P3W-1:0] p3_in, p3_ff;
   logic signed [P4W-1:0] p4_in, p4_ff;
   logic signed [P3W:0]   p3_sum, p3_rnd, p3_clamp;
   logic signed [P4W:0]   p4_sum, gu_rnd;
   logic signed [DSW-1:0] dsilu_ff;
   logic signed [P5W-1:0] p5_in, p5_ff;
   logic signed [P5W:0]   p5_sum, p5_rnd;
   logic signed [UDW-1:0] ud_ff;
   logic signed [P6W-1:0] p6_in, p6_ff;
   logic signed [P6W:0]   p6_sum, gg_rnd;
   logic                  gg_fits, gu_fits;
   logic signed [D-1:0]   gg_in, gu_in;
   logic signed [D-1:0]   gg_ff, gu_out_ff;
   logic                  sat_flag_ff;
   logic                  last_out_ff;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      stage_en[NS-1] = ~valid_ff[NS-1] | rsp_ch.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = ~valid_ff[i] | stage_en[i+1];
      end
   end

   assign req_ch.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stages 0..2: sigmoid front end
   assign sig_ctl.idx_en = stage_en[0];
   assign sig_ctl.rom_en = stage_en[1];
   assign sig_ctl.sel_en = stage_en[2];

   sgmb_sigmoid #(
      .DATA_BITS       (DATA_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
   ) u_sigmoid (
      .clock         (clock),
      .ctl           (sig_ctl),
      .gate_value    (req_ch.gate_value),
      .sig           (sig_s2),
      .one_minus_sig (om_s2)
   );

   // stage 3: g*sig and g*(1-sig)
   assign p1_in = P1W'(g_ff[2]) * P1W'($signed({1'b0, sig_s2}));
   assign p2_in = P1W'(g_ff[2]) * P1W'($signed({1'b0, om_s2}));

   // stage 4: round to silu and 1 + g*(1-sig)
   assign p1_sum = {p1_ff[P1W-1], p1_ff} + (P1W + 1)'(HALF);
   assign p1_rnd = p1_sum >>> F;
   assign p2_sum = {p2_ff[P1W-1], p2_ff} + (P1W + 1)'(HALF);
   assign p2_rnd = p2_sum >>> F;
   assign w_in   = WW'($signed(p2_rnd[SLW-1:0])) + WW'(ONE);

   // stage 5: sig*w and d*silu
   assign p3_in = P3W'($signed({1'b0, sig4_ff})) * P3W'(w_ff);
   assign p4_in = P4W'(d_ff[4]) * P4W'(silu_ff);

   // stage 6: round and clamp dsilu, round up gradient
   assign p3_sum = {p3_ff[P3W-1], p3_ff} + (P3W + 1)'(HALF);
   assign p3_rnd = p3_sum >>> F;
   assign p4_sum = {p4_ff[P4W-1], p4_ff} + (P4W + 1)'(HALF);
   assign gu_rnd = p4_sum >>> F;

   always_comb begin
      if (p3_rnd > DS_LIM) begin
         p3_clamp = DS_LIM;
      end else if (p3_rnd < -DS_LIM) begin
         p3_clamp = -DS_LIM;
      end else begin
         p3_clamp = p3_rnd;
      end
   end

   // stage 7: u*dsilu
   assign p5_in = P5W'(u_ff[6]) * P5W'(dsilu_ff);

   // stage 8: round u*dsilu
   assign p5_sum = {p5_ff[P5W-1], p5_ff} + (P5W + 1)'(HALF);
   assign p5_rnd = p5_sum >>> F;

   // stage 9: d*ud
   assign p6_in = P6W'(d_ff[8]) * P6W'(ud_ff);

   // stage 10: round the gate gradient, saturate both gradients
   assign p6_sum  = {p6_ff[P6W-1], p6_ff} + (P6W + 1)'(HALF);
   assign gg_rnd  = p6_sum >>> F;
   assign gg_fits = (&gg_rnd[GGW-1:D-1]) | ~(|gg_rnd[GGW-1:D-1]);
   assign gu_fits = (&gu_ff[3][GUW-1:D-1]) | ~(|gu_ff[3][GUW-1:D-1]);
   assign gg_in   = gg_fits ? gg_rnd[D-1:0] : (gg_rnd[GGW-1] ? D_MIN : D_MAX);
   assign gu_in   = gu_fits ? gu_ff[3][D-1:0] : (gu_ff[3][GUW-1] ? D_MIN : D_MAX);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         g_ff[0]    <= req_ch.gate_value;
         u_ff[0]    <= req_ch.up_value;
         d_ff[0]    <= req_ch.upstream_gradient;
         last_ff[0] <= req_ch.last_element;
      end
      for (int i = 1; i < 3; i++) begin
         if (stage_en[i]) begin
            g_ff[i] <= g_ff[i-1];
         end
      end
      for (int i = 1; i < 7; i++) begin
         if (stage_en[i]) begin
            u_ff[i] <= u_ff[i-1];
         end
      end
      for (int i = 1; i < 9; i++) begin
         if (stage_en[i]) begin
            d_ff[i] <= d_ff[i-1];
         end
      end
      for (int i = 1; i < 10; i++) begin
         if (stage_en[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
      if (stage_en[3]) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         sig3_ff <= sig_s2;
      end
      if (stage_en[4]) begin
         silu_ff <= p1_rnd[SLW-1:0];
         w_ff    <= w_in;
         sig4_ff <= sig3_ff;
      end
      if (stage_en[5]) begin
         p3_ff <= p3_in;
         p4_ff <= p4_in;
      end
      if (stage_en[6]) begin
         dsilu_ff <= p3_clamp[DSW-1:0];
         gu_ff[0] <= gu_rnd;
      end
      for (int i = 1; i < 4; i++) begin
         if (stage_en[i+6]) begin
            gu_ff[i] <= gu_ff[i-1];
         end
      end
      if (stage_en[7]) begin
         p5_ff <= p5_in;
      end
      if (stage_en[8]) begin
         ud_ff <= p5_rnd[UDW-1:0];
      end
      if (stage_en[9]) begin
         p6_ff <= p6_in;
      end
      if (stage_en[10]) begin
         gg_ff       <= gg_in;
         gu_out_ff   <= gu_in;
         sat_flag_ff <= ~gg_fits | ~gu_fits;
         last_out_ff <= last_ff[9];
      end
   end

   assign rsp_ch.valid         = valid_ff[NS-1];
   assign rsp_ch.gate_gradient = gg_ff;
   assign rsp_ch.up_gradient   = gu_out_ff;
   assign rsp_ch.saturated     = sat_flag_ff;
   assign rsp_ch.last_out      = last_out_ff;

   // a full pipe with a held output takes no transfer
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while pipeline full and stalled");

   // an input transfer always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> valid_ff[0])
      else $error("accepted element lost at pipeline entry");

   // sig and 1-sig leave the front end complementary and in range
   a_sig_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (({1'b0, sig_s2} + {1'b0, om_s2}) == (F + 2)'(ONE)
                       && sig_s2 <= (F + 1)'(ONE)))
      else $error("sigmoid output out of range");

   // the dsilu clamp keeps the most negative code out
   a_dsilu_clamp: assert property (@(posedge clock) disable iff (reset)
      valid_ff[7] |-> dsilu_ff != {1'b1, {(DSW - 1){1'b0}}})
      else $error("dsilu outside clamp range");

   // a clipped result sits on a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.gate_gradient == D_MAX || rsp_ch.gate_gradient == D_MIN ||
          rsp_ch.up_gradient == D_MAX || rsp_ch.up_gradient == D_MIN))
      else $error("saturation flag without a clipped gradient");

endmodule

[rtl/core/sgmb_sigmoid.sv]
// ---------------------------------------------------------------------------
// sgmb_sigmoid
// Three-stage sigmoid front end: table index, table read, sign fold.
// Returns sig and 1 - sig, both unsigned with FRAC_BITS fraction bits.
// ---------------------------------------------------------------------------
module sgmb_sigmoid
   import sgmb_pkg::*;
#(
   parameter int DATA_BITS       = SGMB_DATA_BITS,
   parameter int FRAC_BITS       = SGMB_FRAC_BITS,
   parameter int SIGMOID_ENTRIES = SGMB_SIGMOID_ENTRIES
) (
   input  logic                        clock,
   input  sgmb_sig_ctl_type            ctl,
   input  logic signed [DATA_BITS-1:0] gate_value,
   output logic        [FRAC_BITS:0]   sig,
   output logic        [FRAC_BITS:0]   one_minus_sig
);

   localparam int AW = (DATA_BITS > FRAC_BITS + 4) ? DATA_BITS : FRAC_BITS + 4;
   localparam int KW = $clog2(SIGMOID_ENTRIES);
   localparam int PW = AW + KW + 1;
   localparam logic [AW-1:0]        SAT_LIM = AW'(1) << (FRAC_BITS + 3);
   localparam logic [FRAC_BITS:0]   ONE_Q   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam longint unsigned      Q30     = 64'd1 << 30;
   localparam longint unsigned      H_STEP  = (64'd4 << 30) / SIGMOID_ENTRIES;
   localparam longint unsigned      NUM     = 64'd1 << (30 + FRAC_BITS);

   typedef logic [FRAC_BITS:0] sig_rom_type [SIGMOID_ENTRIES];

   // shift-subtract quotient, only used while the table is built
   function automatic longint unsigned udiv64(longint unsigned num_v,
                                              longint unsigned div_v);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num_v[b]};
         if (rem >= div_v) begin
            rem    = rem - div_v;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid at bin midpoints, via a Taylor series for exp and a geometric step
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type     rom;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q;
      longint unsigned p;
      longint unsigned den;
      term = Q30;
      sum  = Q30;
      for (int i = 1; i <= 12; i++) begin
         term = udiv64((term * H_STEP) >> 30, 64'(i));
         if (i[0] == 1'b1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      q = (sum * sum + (Q30 >> 1)) >> 30;
      p = sum;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         den    = Q30 + p;
         rom[k] = (FRAC_BITS + 1)'(udiv64(NUM + (den >> 1), den));
         p      = (p * q + (Q30 >> 1)) >> 30;
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

   logic [DATA_BITS-1:0] mag;
   logic                 neg;
   logic                 sat_in;
   logic [PW-1:0]        idx_prod;
   logic [PW-1:0]        idx_shift;
   logic [KW-1:0]        k_in;

   logic [KW-1:0]        k_ff;
   logic                 neg_a_ff;
   logic                 sat_a_ff;
   logic [FRAC_BITS:0]   rom_ff;
   logic                 neg_b_ff;
   logic                 sat_b_ff;
   logic [FRAC_BITS:0]   sig_in;
   logic [FRAC_BITS:0]   sig_ff;
   logic [FRAC_BITS:0]   om_ff;

   // magnitude is exact for the most negative code as an unsigned value
   assign neg       = gate_value[DATA_BITS-1];
   assign mag       = neg ? (~gate_value) + DATA_BITS'(1) : gate_value;
   assign sat_in    = AW'(mag) >= SAT_LIM;
   assign idx_prod  = PW'(mag) * PW'(SIGMOID_ENTRIES);
   assign idx_shift = idx_prod >> (FRAC_BITS + 3);
   assign k_in      = (idx_shift >= PW'(SIGMOID_ENTRIES)) ? KW'(SIGMOID_ENTRIES - 1)
                                                          : idx_shift[KW-1:0];

   always_comb begin
      if (sat_b_ff) begin
         sig_in = neg_b_ff ? '0 : ONE_Q;
      end else begin
         sig_in = neg_b_ff ? ONE_Q - rom_ff : rom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.idx_en) begin
         k_ff     <= k_in;
         neg_a_ff <= neg;
         sat_a_ff <= sat_in;
      end
      if (ctl.rom_en) begin
         rom_ff   <= SIG_ROM[k_ff];
         neg_b_ff <= neg_a_ff;
         sat_b_ff <= sat_a_ff;
      end
      if (ctl.sel_en) begin
         sig_ff <= sig_in;
         om_ff  <= ONE_Q - sig_in;
      end
   end

   assign sig           = sig_ff;
   assign one_minus_sig = om_ff;

endmodule

[dv/silu_gated_multiply_backward_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// silu_gated_multiply_backward_top_tb
// Streams gate/up/gradient elements into the block under three idle
// profiles, with a long output hold-off, and checks every result against an
// in-bench model of the sigmoid table and the fixed-point gradient math.
// ---------------------------------------------------------------------------
module silu_gated_multiply_backward_top_tb;
   import sgmb_pkg::*;

   localparam int DB          = SGMB_DATA_BITS;
   localparam int FB          = SGMB_FRAC_BITS;
   localparam int ENTRIES     = SGMB_SIGMOID_ENTRIES;
   localparam int LATENCY     = 11;
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 200000;
   localparam longint ONE     = 64'sd1 <<< FB;
   localparam longint DMAX    = (64'sd1 <<< (DB - 1)) - 1;
   localparam longint DMIN    = -(64'sd1 <<< (DB - 1));

   typedef struct packed {
      logic signed [DB-1:0] gate_value;
      logic signed [DB-1:0] up_value;
      logic signed [DB-1:0] upstream_gradient;
      logic                 last_element;
   } element_type;

   typedef struct packed {
      logic signed [DB-1:0] gate_gradient;
      logic signed [DB-1:0] up_gradient;
      logic                 saturated;
      logic                 last_out;
   } gradient_type;

   class gradient_scoreboard_type;
      longint unsigned sig_table [ENTRIES];
      gradient_type    expected_gradients [$];
      int              failures;
      int              checked;
      int              saturated_seen;

      function new();
         longint unsigned q30, h, term, sum, q, p, den, num;
         q30 = 64'd1 << 30;
         h = (64'd4 << 30) / ENTRIES;
         num = 64'd1 << (30 + FB);
         term = q30;
         sum = q30;
         failures = 0;
         checked = 0;
         saturated_seen = 0;
         // exp(-4/N) as a truncated taylor series in q30
         for (int i = 1; i <= 12; i++) begin
            term = ((term * h) >> 30) / longint'(i);
            if (i % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         q = (sum * sum + (q30 >> 1)) >> 30;
         p = sum;
         for (int k = 0; k < ENTRIES; k++) begin
            den = q30 + p;
            sig_table[k] = (num + (den >> 1)) / den;
            p = (p * q + (q30 >> 1)) >> 30;
         end
      endfunction

      function longint round_q(longint v);
         return (v + (64'sd1 <<< (FB - 1))) >>> FB;
      endfunction

      function longint clip_data(longint v, ref bit hit);
         if (v > DMAX) begin
            hit = 1'b1;
            return DMAX;
         end
         if (v < DMIN) begin
            hit = 1'b1;
            return DMIN;
         end
         return v;
      endfunction

      function gradient_type predict_gradients(element_type e);
         longint       g, u, d, a, sig, silu, dsilu, ud, gg, gu;
         int           k;
         bit           hit;
         gradient_type r;
         g = $signed(e.gate_value);
         u = $signed(e.up_value);
         d = $signed(e.upstream_gradient);
         hit = 1'b0;
         a = (g < 0) ? -g : g;
         // table bypass once the gate is at or past +-8
         if (a >= 8 * ONE) begin
            sig = (g < 0) ? 0 : ONE;
         end else begin
            k = int'((a * ENTRIES) >>> (FB + 3));
            if (k >= ENTRIES) k = ENTRIES - 1;
            sig = (g < 0) ? ONE - longint'(sig_table[k]) : longint'(sig_table[k]);
         end
         silu = round_q(g * sig);
         dsilu = round_q(sig * (ONE + round_q(g * (ONE - sig))));
         if (dsilu > 2 * ONE - 1) dsilu = 2 * ONE - 1;
         if (dsilu < -(2 * ONE - 1)) dsilu = -(2 * ONE - 1);
         ud = round_q(u * dsilu);
         gg = clip_data(round_q(d * ud), hit);
         gu = clip_data(round_q(d * silu), hit);
         r.gate_gradient = gg[DB-1:0];
         r.up_gradient = gu[DB-1:0];
         r.saturated = hit;
         r.last_out = e.last_element;
         return r;
      endfunction

      function void flag_failure(string what, gradient_type want, gradient_type got);
         failures++;
         if (failures <= 10) begin
            $display("%0t: %s: exp gate=%0d up=%0d sat=%0b last=%0b",
                     $time, what, $signed(want.gate_gradient), $signed(want.up_gradient),
                     want.saturated, want.last_out);
            $display("%0t: %s: got gate=%0d up=%0d sat=%0b last=%0b",
                     $time, what, $signed(got.gate_gradient), $signed(got.up_gradient),
                     got.saturated, got.last_out);
         end
      endfunction

      function void note_element(element_type e);
         expected_gradients.push_back(predict_gradients(e));
      endfunction

      function void check_result(gradient_type got);
         gradient_type want;
         if (expected_gradients.size() == 0) begin
            flag_failure("result with nothing outstanding", '0, got);
            return;
         end
         want = expected_gradients.pop_front();
         checked++;
         if (got.saturated === 1'b1) saturated_seen++;
         if (got.gate_gradient !== want.gate_gradient || got.up_gradient !== want.up_gradient ||
             got.saturated !== want.saturated || got.last_out !== want.last_out)
            flag_failure("gradient mismatch", want, got);
      endfunction

      function int pending();
         return expected_gradients.size();
      endfunction

      function void flag_leftovers();
         while (expected_gradients.size() > 0)
            flag_failure("result never arrived", expected_gradients.pop_front(), '0);
      endfunction
   endclass

   logic clock;
   logic reset;

   sgmb_req_if #(.DATA_BITS(DB)) req_ch ();
   sgmb_rsp_if #(.DATA_BITS(DB)) rsp_ch ();

   silu_gated_multiply_backward_top #(
      .DATA_BITS       (DB),
      .FRAC_BITS       (FB),
      .SIGMOID_ENTRIES (ENTRIES)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gradient_scoreboard_type sb;
   int send_idle_pct;
   int recv_idle_pct  = 0;
   int stall_requests = 0;
   int stalls_served;
   int hold_left;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: random backpressure plus an occasional long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      stalls_served = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      gradient_type got;
      got.gate_gradient = rsp_ch.gate_gradient;
      got.up_gradient = rsp_ch.up_gradient;
      got.saturated = rsp_ch.saturated;
      got.last_out = rsp_ch.last_out;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) sb.check_result(got);
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_element(input element_type e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.gate_value <= e.gate_value;
      req_ch.up_value <= e.up_value;
      req_ch.upstream_gradient <= e.upstream_gradient;
      req_ch.last_element <= e.last_element;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sb.note_element(e);
      @(negedge clock);
   endtask

   task automatic send_fields(input int g, input int u, input int d, input bit last);
      element_type e;
      e.gate_value = g[DB-1:0];
      e.up_value = u[DB-1:0];
      e.upstream_gradient = d[DB-1:0];
      e.last_element = last;
      send_element(e);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() > 0) @(negedge clock);
   endtask

   function automatic element_type random_element();
      element_type e;
      int          pick;
      pick = $urandom_range(9);
      e.gate_value = DB'($urandom());
      e.up_value = DB'($urandom());
      e.upstream_gradient = DB'($urandom());
      unique case (pick)
         0, 1, 2, 3: begin
            // table region with moderate operands, mostly unsaturated
            e.gate_value = DB'($urandom_range(18000) - 9000);
            e.up_value = DB'($urandom_range(8192) - 4096);
            e.upstream_gradient = DB'($urandom_range(8192) - 4096);
         end
         4: begin
            e.up_value = DB'($urandom_range(2048) - 1024);
            e.upstream_gradient = DB'($urandom_range(2048) - 1024);
         end
         5: begin
            e.gate_value = DB'(($urandom_range(1) ? 8192 : -8192) + $urandom_range(8) - 4);
         end
         6: begin
            e.up_value = $urandom_range(1) ? DB'(DMAX) : DB'(DMIN);
            e.upstream_gradient = $urandom_range(1) ? DB'(DMAX) : DB'(DMIN);
         end
         default: begin
         end
      endcase
      e.last_element = ($urandom_range(15) == 0);
      return e;
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      send_idle_pct = 0;
      req_ch.valid = 1'b0;
      req_ch.gate_value = '0;
      req_ch.up_value = '0;
      req_ch.upstream_gradient = '0;
      req_ch.last_element = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero gate, table edges, bypass at +-8, extremes, saturation
      send_fields(0, 1024, 1024, 1'b0);
      send_fields(1, 1024, 1024, 1'b0);
      send_fields(-1, 1024, 1024, 1'b0);
      send_fields(32, 2048, -1024, 1'b0);
      send_fields(1024, 1024, 1024, 1'b0);
      send_fields(-1024, 1024, 1024, 1'b0);
      send_fields(8160, -3000, 700, 1'b0);
      send_fields(8191, 1024, 1024, 1'b0);
      send_fields(-8191, 1024, 1024, 1'b0);
      send_fields(8192, 1024, 1024, 1'b0);
      send_fields(-8192, 1024, 1024, 1'b0);
      send_fields(32767, 32767, 32767, 1'b0);
      send_fields(32767, 32767, -32768, 1'b0);
      send_fields(-32768, 32767, 32767, 1'b0);
      send_fields(-32768, -32768, -32768, 1'b0);
      send_fields(2000, -32768, 32767, 1'b0);
      send_fields(-2000, 32767, -32768, 1'b0);
      send_fields(20000, 0, 32767, 1'b0);
      send_fields(0, 32767, 32767, 1'b0);
      send_fields(-300, -32768, 0, 1'b0);
      send_fields(5000, 100, -200, 1'b1);
      send_fields(-5000, -100, 200, 1'b1);
      drain_results();

      send_idle_pct = 23;
      recv_idle_pct <= 50;
      repeat (130) send_element(random_element());
      drain_results();

      send_idle_pct = 50;
      recv_idle_pct <= 23;
      repeat (130) send_element(random_element());
      drain_results();

      // no idling; output held off long enough for the pipe to fill and stall
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      stall_requests <= stall_requests + 1;
      repeat (140) send_element(random_element());
      drain_results();

      repeat (2 * LATENCY) @(negedge clock);
      sb.flag_leftovers();
      $display("checked %0d elements: directed edges, three idle profiles, a %0d-cycle hold-off",
               sb.checked, HOLD_CYCLES);
      $display("%0d results saturated, %0d failures", sb.saturated_seen, sb.failures);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
